/* rtl/bus_register_read_master_assert.svh */
// ----------------------------------------------------------------------------
// bus_register_read_master_assert.svh
// assertion macros for the bus register read master rtl
// ----------------------------------------------------------------------------
`ifndef BUS_REGISTER_READ_MASTER_ASSERT_SVH
`define BUS_REGISTER_READ_MASTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BRRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brrm assertion failed");

// antecedent implies consequent in the next cycle
`define BRRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brrm assertion failed");

`endif

/* rtl/brrm_pkg.sv */
// ----------------------------------------------------------------------------
// brrm_pkg
// types, codes and crc helper for the bus register read master
// ----------------------------------------------------------------------------
package brrm_pkg;

  localparam int LEN_W   = 9;
  localparam int CNT_W   = 6;
  localparam int HDR_LEN = 6;

  localparam logic [LEN_W-1:0] FRAME_LEN = 9'd7;
  localparam logic [LEN_W-1:0] LEN_MAX   = 9'd511;

  // reflected form of the maxim crc-8 polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LENGTH    = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_ADDRESS   = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE = 3'd5;
  localparam logic [2:0] ST_NONE      = 3'd6;

  localparam logic [1:0] REG_OWN_ADDR   = 2'd0;
  localparam logic [1:0] REG_READ_CODE  = 2'd1;
  localparam logic [1:0] REG_REPLY_CODE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX,
    S_HDR_RD,
    S_HDR_CMP,
    S_DAT_RD,
    S_DAT_EMIT,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] status;
    logic       last;
  } res_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/brrm_reply_mem.sv */
// ----------------------------------------------------------------------------
// brrm_reply_mem
// reply frame store, one write and one registered read port
// ----------------------------------------------------------------------------
module brrm_reply_mem #(
  parameter int DEPTH  = 38,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/brrm_out_reg.sv */
// ----------------------------------------------------------------------------
// brrm_out_reg
// result output register with valid/ready handshake
// ----------------------------------------------------------------------------
module brrm_out_reg
  import brrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       slot_free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte_value,
  output logic [2:0] out_status,
  output logic       out_last
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = res_r.kind;
  assign out_byte_value = res_r.byte_value;
  assign out_status     = res_r.status;
  assign out_last       = res_r.last;

endmodule

/* rtl/bus_register_read_master.sv */
// ----------------------------------------------------------------------------
// bus_register_read_master
// register-read master: emits crc-8 framed requests, stores and checks replies
// ----------------------------------------------------------------------------
// request item: 7 frame bytes, one per unstalled cycle from the cycle after accept
// reply byte item: one reply store write while a request is open and the byte fits
// end item: header bytes read and checked (up to 6), data bytes read, then status
// rate set by the single read port of the reply store and the one result register
// reset clears control and configuration; the reply store is not cleared
// ----------------------------------------------------------------------------
module bus_register_read_master
  import brrm_pkg::*;
#(
  parameter int MAX_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_target_address,
  input  logic [7:0] in_start_register,
  input  logic [7:0] in_read_count,
  input  logic [7:0] in_reply_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte_value,
  output logic [2:0] out_status,
  output logic       out_last
);

  `include "bus_register_read_master_assert.svh"

  localparam int MEM_DEPTH = HDR_LEN + MAX_COUNT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  state_t state_r, state_nxt;

  logic [7:0]       own_addr_r, read_code_r, reply_code_r;
  logic             pending_r, pending_nxt;
  logic [7:0]       target_r, target_nxt;
  logic [7:0]       register_r, register_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] rx_len_r, rx_len_nxt;
  logic [7:0]       rx_crc_r, rx_crc_nxt;
  logic             crc_ok_r, crc_ok_nxt;
  logic [7:0]       tx_crc_r, tx_crc_nxt;
  logic [2:0]       tx_idx_r, tx_idx_nxt;
  logic [2:0]       hdr_idx_r, hdr_idx_nxt;
  logic [CNT_W-1:0] dat_idx_r, dat_idx_nxt;
  logic [2:0]       status_r, status_nxt;

  logic              accept;
  logic              slot_free;
  logic              res_load;
  res_t              res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic [7:0]        tx_byte;
  logic [7:0]        hdr_expect;
  logic              too_large;
  logic              len_ok;
  logic              hdr_mismatch;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign too_large = (in_read_count > 8'(MAX_COUNT));
  assign len_ok    = (rx_len_r == (LEN_W'(count_r) + FRAME_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r   <= '0;
      read_code_r  <= '0;
      reply_code_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_ADDR:   own_addr_r   <= cfg_wdata;
        REG_READ_CODE:  read_code_r  <= cfg_wdata;
        REG_REPLY_CODE: reply_code_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (tx_idx_r)
      3'd0:    tx_byte = own_addr_r;
      3'd1:    tx_byte = target_r;
      3'd2:    tx_byte = read_code_r;
      3'd3:    tx_byte = 8'h00;
      3'd4:    tx_byte = register_r;
      3'd5:    tx_byte = 8'(count_r);
      default: tx_byte = tx_crc_r;
    endcase
  end

  always_comb begin
    case (hdr_idx_r)
      3'd0:    hdr_expect = target_r;
      3'd1:    hdr_expect = own_addr_r;
      3'd2:    hdr_expect = reply_code_r;
      3'd3:    hdr_expect = 8'h00;
      3'd4:    hdr_expect = register_r;
      default: hdr_expect = 8'(count_r);
    endcase
  end

  assign hdr_mismatch = (mem_rdata != hdr_expect);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_REQ: begin
              state_nxt = too_large ? S_STATUS : S_TX;
            end
            MODE_END: begin
              if (!pending_r || !len_ok || !crc_ok_r) begin
                state_nxt = S_STATUS;
              end else begin
                state_nxt = S_HDR_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TX: begin
        if (slot_free && tx_idx_r == 3'd6) begin
          state_nxt = S_IDLE;
        end
      end
      S_HDR_RD: begin
        state_nxt = S_HDR_CMP;
      end
      S_HDR_CMP: begin
        if (hdr_mismatch || (hdr_idx_r == 3'(HDR_LEN - 1) && count_r == '0)) begin
          state_nxt = S_STATUS;
        end else if (hdr_idx_r == 3'(HDR_LEN - 1)) begin
          state_nxt = S_DAT_RD;
        end else begin
          state_nxt = S_HDR_RD;
        end
      end
      S_DAT_RD: begin
        state_nxt = S_DAT_EMIT;
      end
      S_DAT_EMIT: begin
        if (slot_free) begin
          state_nxt = (dat_idx_r == count_r - 1'b1) ? S_STATUS : S_DAT_RD;
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    pending_nxt  = pending_r;
    target_nxt   = target_r;
    register_nxt = register_r;
    count_nxt    = count_r;
    rx_len_nxt   = rx_len_r;
    rx_crc_nxt   = rx_crc_r;
    crc_ok_nxt   = crc_ok_r;
    tx_crc_nxt   = tx_crc_r;
    tx_idx_nxt   = tx_idx_r;
    hdr_idx_nxt  = hdr_idx_r;
    dat_idx_nxt  = dat_idx_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_waddr    = rx_len_r[ADDR_W-1:0];
    mem_re       = 1'b0;
    mem_raddr    = ADDR_W'(hdr_idx_r);
    res_load     = 1'b0;
    res          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_REQ: begin
              if (too_large) begin
                status_nxt = ST_TOO_LARGE;
              end else begin
                pending_nxt  = 1'b1;
                target_nxt   = in_target_address;
                register_nxt = in_start_register;
                count_nxt    = in_read_count[CNT_W-1:0];
                rx_len_nxt   = '0;
                rx_crc_nxt   = '0;
                crc_ok_nxt   = 1'b0;
                tx_crc_nxt   = '0;
                tx_idx_nxt   = '0;
              end
            end
            MODE_BYTE: begin
              if (pending_r) begin
                crc_ok_nxt = (in_reply_byte == rx_crc_r);
                rx_crc_nxt = crc8_update(rx_crc_r, in_reply_byte);
                mem_we     = (rx_len_r < (LEN_W'(count_r) + LEN_W'(HDR_LEN)));
                if (rx_len_r != LEN_MAX) begin
                  rx_len_nxt = rx_len_r + 1'b1;
                end
              end
            end
            MODE_END: begin
              pending_nxt = 1'b0;
              hdr_idx_nxt = '0;
              dat_idx_nxt = '0;
              if (!pending_r) begin
                status_nxt = ST_NONE;
              end else if (!len_ok) begin
                status_nxt = ST_LENGTH;
              end else if (!crc_ok_r) begin
                status_nxt = ST_CRC;
              end else begin
                status_nxt = ST_OK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TX: begin
        if (slot_free) begin
          res_load       = 1'b1;
          res.kind       = KIND_TX;
          res.byte_value = tx_byte;
          res.last       = (tx_idx_r == 3'd6);
          tx_crc_nxt     = crc8_update(tx_crc_r, tx_byte);
          tx_idx_nxt     = tx_idx_r + 1'b1;
        end
      end
      S_HDR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(hdr_idx_r);
      end
      S_HDR_CMP: begin
        if (hdr_mismatch) begin
          status_nxt = (hdr_idx_r < 3'd2) ? ST_ADDRESS : ST_MISMATCH;
        end else begin
          hdr_idx_nxt = hdr_idx_r + 1'b1;
        end
      end
      S_DAT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(dat_idx_r) + ADDR_W'(HDR_LEN);
      end
      S_DAT_EMIT: begin
        if (slot_free) begin
          res_load       = 1'b1;
          res.kind       = KIND_DATA;
          res.byte_value = mem_rdata;
          dat_idx_nxt    = dat_idx_r + 1'b1;
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res.kind   = KIND_STATUS;
          res.status = status_r;
          res.last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pending_r  <= 1'b0;
      target_r   <= '0;
      register_r <= '0;
      count_r    <= '0;
      rx_len_r   <= '0;
      rx_crc_r   <= '0;
      crc_ok_r   <= 1'b0;
      tx_crc_r   <= '0;
      tx_idx_r   <= '0;
      hdr_idx_r  <= '0;
      dat_idx_r  <= '0;
      status_r   <= ST_OK;
    end else begin
      state_r    <= state_nxt;
      pending_r  <= pending_nxt;
      target_r   <= target_nxt;
      register_r <= register_nxt;
      count_r    <= count_nxt;
      rx_len_r   <= rx_len_nxt;
      rx_crc_r   <= rx_crc_nxt;
      crc_ok_r   <= crc_ok_nxt;
      tx_crc_r   <= tx_crc_nxt;
      tx_idx_r   <= tx_idx_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      dat_idx_r  <= dat_idx_nxt;
      status_r   <= status_nxt;
    end
  end

  brrm_reply_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_reply_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_reply_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  brrm_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (res_load),
    .res            (res),
    .slot_free      (slot_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte_value (out_byte_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  `BRRM_ASSERT_NEXT(a_req_starts_frame, clk, rst_n,
    accept && in_mode == MODE_REQ && !too_large, state_r == S_TX && tx_idx_r == 3'd0)
  `BRRM_ASSERT_SAME(a_store_in_range, clk, rst_n,
    mem_we, rx_len_r < LEN_W'(MEM_DEPTH))
  `BRRM_ASSERT_SAME(a_data_in_count, clk, rst_n,
    state_r == S_DAT_EMIT, dat_idx_r < count_r)
  `BRRM_ASSERT_SAME(a_done_with_last, clk, rst_n,
    state_r != S_IDLE && state_nxt == S_IDLE, res_load && res.last)

endmodule

/* verif/bus_register_read_master_tb.sv */
// ----------------------------------------------------------------------------
// bus_register_read_master_tb
// Self-checking bench for the register-read bus master. A short table of
// directed items covers the corner cases: refused counts, end with nothing
// open, ignored items, abandoned requests and crc faults. Randomized read
// transactions follow, with length, crc, address and field faults, abandoned
// replies and noise. Each random transaction but an abandoned one ends with an
// end item. A model of the master predicts every transmit byte, data byte and
// status, and each result is checked against it in order. This runs over four
// register settings and three idle and stall patterns on both handshakes.
// ----------------------------------------------------------------------------
module bus_register_read_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brrm_pkg::*;

  localparam int MAX_CNT     = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL  = 100;

  localparam logic [7:0] MAXIM_POLY_REFL = 8'h8C;
  localparam logic [1:0] MODE_UNUSED     = 2'd3;

  localparam logic [1:0] FILL_AS_IS   = 2'd0;
  localparam logic [1:0] FILL_CRC     = 2'd1;
  localparam logic [1:0] FILL_BAD_CRC = 2'd2;

  typedef enum {
    FLAW_NONE, FLAW_SHORT, FLAW_LONG, FLAW_CRC, FLAW_ADDR, FLAW_FIELD, FLAW_ABANDON
  } flaw_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] tgt;
    logic [7:0] first;
    logic [7:0] cnt;
    logic [7:0] byt;
    logic [1:0] fill;
    logic       typed;
    logic [2:0] st;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = 2'd0;
  logic [7:0] in_target_address = 8'h00;
  logic [7:0] in_start_register = 8'h00;
  logic [7:0] in_read_count = 8'h00;
  logic [7:0] in_reply_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte_value;
  logic [2:0] out_status;
  logic       out_last;

  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int fails = 0;
  int counted = 0;
  int unsigned cyc = 0;

  // register mirror
  logic [7:0] cur_own = 8'h00;
  logic [7:0] cur_read_code = 8'h00;
  logic [7:0] cur_reply_code = 8'h00;

  // transaction state mirror
  logic       open_req = 1'b0;
  logic [7:0] req_target = 8'h00;
  logic [7:0] req_register = 8'h00;
  logic [5:0] req_count = 6'd0;
  logic [8:0] rx_len = 9'd0;
  logic [7:0] rx_crc = 8'h00;
  logic       rx_crc_hit = 1'b0;
  logic [7:0] rx_hdr [6];
  logic [7:0] rx_data [MAX_CNT];

  res_t master_out_q [$];

  step_row_t plan [28] = '{
    '{MODE_END,    8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b1, ST_NONE},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'hFF, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_REQ,    8'h00, 8'h00, 8'd33, 8'h00, FILL_AS_IS,   1'b1, ST_TOO_LARGE},
    '{MODE_REQ,    8'hFF, 8'hFF, 8'hFF, 8'hFF, FILL_AS_IS,   1'b1, ST_TOO_LARGE},
    '{MODE_REQ,    8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_REQ,    8'hFF, 8'hFF, 8'd32, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_END,    8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b1, ST_LENGTH},
    '{MODE_REQ,    8'h12, 8'h34, 8'h01, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h12, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h34, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h01, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'hA5, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_CRC,     1'b0, ST_OK},
    '{MODE_END,    8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_END,    8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b1, ST_NONE},
    '{MODE_REQ,    8'h80, 8'h7F, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h80, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h7F, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b0, ST_OK},
    '{MODE_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, FILL_BAD_CRC, 1'b0, ST_OK},
    '{MODE_END,    8'h00, 8'h00, 8'h00, 8'h00, FILL_AS_IS,   1'b1, ST_CRC}
  };

  bus_register_read_master #(.MAX_COUNT(MAX_CNT)) dut (.*);

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // crc-8 maxim, reflected, fed one input bit at a time
  function automatic logic [7:0] maxim_crc8(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r = r >> 1;
      if (fb) r = r ^ MAXIM_POLY_REFL;
    end
    return r;
  endfunction

  function automatic void owe(logic [1:0] k, logic [7:0] v, logic [2:0] s, logic l);
    master_out_q.push_back('{k, v, s, l});
  endfunction

  task automatic master_step(input logic [1:0] md, input logic [7:0] tgt, first, cnt,
                             input logic [7:0] byt, output bit no_effect);
    logic [7:0] frame [6];
    logic [7:0] c;
    logic [2:0] verdict;
    int pos;
    no_effect = 1'b0;
    case (md)
      MODE_REQ: begin
        if (int'(cnt) > MAX_CNT) begin
          owe(KIND_STATUS, 8'h00, ST_TOO_LARGE, 1'b1);
        end else begin
          req_target = tgt;
          req_register = first;
          req_count = cnt[5:0];
          open_req = 1'b1;
          rx_len = 9'd0;
          rx_crc = 8'h00;
          rx_crc_hit = 1'b0;
          frame[0] = cur_own;
          frame[1] = tgt;
          frame[2] = cur_read_code;
          frame[3] = 8'h00;
          frame[4] = first;
          frame[5] = {2'b00, cnt[5:0]};
          c = 8'h00;
          for (int i = 0; i < 6; i++) begin
            c = maxim_crc8(c, frame[i]);
            owe(KIND_TX, frame[i], ST_OK, 1'b0);
          end
          owe(KIND_TX, c, ST_OK, 1'b1);
        end
      end
      MODE_BYTE: begin
        if (!open_req) begin
          no_effect = 1'b1;
        end else begin
          pos = int'(rx_len);
          rx_crc_hit = (byt == rx_crc);
          rx_crc = maxim_crc8(rx_crc, byt);
          if (pos < 6) rx_hdr[pos] = byt;
          else if (pos - 6 < int'(req_count)) rx_data[pos - 6] = byt;
          if (rx_len != 9'd511) rx_len = rx_len + 9'd1;
        end
      end
      MODE_END: begin
        if (!open_req) begin
          owe(KIND_STATUS, 8'h00, ST_NONE, 1'b1);
        end else begin
          open_req = 1'b0;
          if (int'(rx_len) != int'(req_count) + 7) verdict = ST_LENGTH;
          else if (!rx_crc_hit) verdict = ST_CRC;
          else if (rx_hdr[0] != req_target || rx_hdr[1] != cur_own) verdict = ST_ADDRESS;
          else if (rx_hdr[2] != cur_reply_code || rx_hdr[3] != 8'h00 ||
                   rx_hdr[4] != req_register || rx_hdr[5] != {2'b00, req_count})
            verdict = ST_MISMATCH;
          else verdict = ST_OK;
          if (verdict == ST_OK) begin
            for (int i = 0; i < int'(req_count); i++) owe(KIND_DATA, rx_data[i], ST_OK, 1'b0);
          end
          owe(KIND_STATUS, 8'h00, verdict, 1'b1);
        end
      end
      default: no_effect = 1'b1;
    endcase
  endtask

  task automatic drive_item(input logic [1:0] md, input logic [7:0] tgt, first, cnt,
                            input logic [7:0] byt);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_target_address <= tgt;
    in_start_register <= first;
    in_read_count <= cnt;
    in_reply_byte <= byt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue(input logic [1:0] md, input logic [7:0] tgt, first, cnt,
                       input logic [7:0] byt);
    bit quiet;
    master_step(md, tgt, first, cnt, byt, quiet);
    if (!quiet) counted++;
    drive_item(md, tgt, first, cnt, byt);
  endtask

  task automatic send_byte(input logic [7:0] byt);
    issue(MODE_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), byt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (master_out_q.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_regs(input logic [7:0] own, rd, rp);
    cfg_we <= 1'b1;
    cfg_index <= REG_OWN_ADDR;
    cfg_wdata <= own;
    @(negedge clk);
    cfg_index <= REG_READ_CODE;
    cfg_wdata <= rd;
    @(negedge clk);
    cfg_index <= REG_REPLY_CODE;
    cfg_wdata <= rp;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_own = own;
    cur_read_code = rd;
    cur_reply_code = rp;
  endtask

  task automatic read_transaction();
    logic [7:0] hdr [6];
    logic [7:0] tgt, first, cnt;
    flaw_t flaw;
    int pick, k, total, cut;
    tgt = 8'($urandom);
    first = 8'($urandom);
    cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(MAX_CNT)) : 8'($urandom_range(6));
    pick = $urandom_range(99);
    flaw = pick < 45 ? FLAW_NONE : pick < 53 ? FLAW_SHORT : pick < 60 ? FLAW_LONG :
           pick < 68 ? FLAW_CRC : pick < 78 ? FLAW_ADDR : pick < 90 ? FLAW_FIELD :
           FLAW_ABANDON;
    issue(MODE_REQ, tgt, first, cnt, 8'($urandom));
    hdr[0] = tgt;
    hdr[1] = cur_own;
    hdr[2] = cur_reply_code;
    hdr[3] = 8'h00;
    hdr[4] = first;
    hdr[5] = cnt;
    if (flaw == FLAW_ADDR) begin
      k = $urandom_range(1);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end else if (flaw == FLAW_FIELD) begin
      k = $urandom_range(2, 5);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end
    total = 6 + int'(cnt);
    cut = (flaw == FLAW_SHORT || flaw == FLAW_ABANDON) ? $urandom_range(total) : total;
    for (k = 0; k < cut; k++) send_byte(k < 6 ? hdr[k] : 8'($urandom));
    if (flaw == FLAW_ABANDON) return;
    if (flaw == FLAW_CRC) send_byte(rx_crc ^ (8'h01 << $urandom_range(7)));
    else if (flaw != FLAW_SHORT) send_byte(rx_crc);
    if (flaw == FLAW_LONG) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    issue(MODE_END, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(input int quota);
    int stop;
    stop = counted + quota;
    while (counted < stop) begin
      if ($urandom_range(99) < 15) begin
        issue(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        read_transaction();
      end
      if ($urandom_range(99) < 4) drain();
    end
  endtask

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (master_out_q.size() == 0) begin
        $display("%0t: result with none due, got kind %0d byte %0d status %0d last %0d",
                 $time, out_kind, out_byte_value, out_status, out_last);
        fails++;
      end else begin
        want = master_out_q.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("byte_value", want.byte_value, out_byte_value);
        check_field("status", want.status, out_status);
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    step_row_t r;
    logic [7:0] b;
    int n0;
    bit quiet;
    in_gap_pct = 16;
    out_stall_pct = 67;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    write_regs(8'h00, 8'h00, 8'h00);

    foreach (plan[i]) begin
      r = plan[i];
      b = (r.fill == FILL_CRC) ? rx_crc : (r.fill == FILL_BAD_CRC) ? (rx_crc ^ 8'h01) : r.byt;
      n0 = master_out_q.size();
      master_step(r.mode, r.tgt, r.first, r.cnt, b, quiet);
      if (r.typed) begin
        while (master_out_q.size() > n0) void'(master_out_q.pop_back());
        owe(KIND_STATUS, 8'h00, r.st, 1'b1);
      end
      drive_item(r.mode, r.tgt, r.first, r.cnt, b);
    end
    settle();

    write_regs(8'hFF, 8'hFF, 8'hFF);
    random_phase(140);
    settle();

    write_regs(8'($urandom), 8'($urandom), 8'($urandom));
    in_gap_pct = 67;
    out_stall_pct = 16;
    random_phase(140);
    settle();

    write_regs(8'($urandom), 8'h01, 8'h80);
    in_gap_pct = 0;
    out_stall_pct = 0;
    random_phase(140);
    settle();

    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
